FILE: sv/llsg_pkg.sv
`default_nettype none
package llsg_pkg;

    localparam int LEN_W   = 31;
    localparam int BEATS_W = 16;
    localparam int BYTE_W  = 8;
    localparam int GDIV_W  = 3;
    localparam int NUM_W   = 20;
    localparam int DEN_W   = 8;
    localparam int POS_W   = 32;
    localparam int IDX_W   = 20;
    localparam int CIDX_W  = 8;
    localparam int CDATA_W = 32;
    localparam int SPAN_W  = LEN_W + DEN_W;
    localparam int OUT_W   = 56;

    localparam logic [CIDX_W-1:0] REG_LOOP_LEN    = 8'd0;
    localparam logic [CIDX_W-1:0] REG_TOTAL_BEATS = 8'd1;
    localparam logic [CIDX_W-1:0] REG_BEATS_BAR   = 8'd2;
    localparam logic [CIDX_W-1:0] REG_NOTE_VALUE  = 8'd3;
    localparam logic [CIDX_W-1:0] REG_GRID_DIV    = 8'd4;

    localparam logic [GDIV_W-1:0] GDIV_OFF       = 3'd0;
    localparam logic [GDIV_W-1:0] GDIV_BAR       = 3'd1;
    localparam logic [GDIV_W-1:0] GDIV_HALF      = 3'd2;
    localparam logic [GDIV_W-1:0] GDIV_QUARTER   = 3'd3;
    localparam logic [GDIV_W-1:0] GDIV_EIGHTH    = 3'd4;
    localparam logic [GDIV_W-1:0] GDIV_SIXTEENTH = 3'd5;

    typedef struct packed {
        logic [LEN_W-1:0]  loop_len;
        logic [NUM_W-1:0]  ratio_num;
        logic [DEN_W-1:0]  ratio_den;
        logic [SPAN_W-1:0] span;
        logic              grid_valid;
    } cfg_t;

endpackage
`default_nettype wire

FILE: sv/llsg_cfg.sv
`default_nettype none
module llsg_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    input  wire logic [llsg_pkg::CIDX_W-1:0]  cfg_index,
    input  wire logic [llsg_pkg::CDATA_W-1:0] cfg_data,
    output llsg_pkg::cfg_t                    cfg
);
    import llsg_pkg::*;

    logic [LEN_W-1:0]   loop_len_reg, loop_len_next;
    logic [BEATS_W-1:0] beats_reg, beats_next;
    logic [BYTE_W-1:0]  bpb_reg, bpb_next;
    logic [BYTE_W-1:0]  note_reg, note_next;
    logic [GDIV_W-1:0]  gdiv_reg, gdiv_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [SPAN_W-1:0]  span_reg, span_next;

    always_comb
    begin
        loop_len_next = loop_len_reg;
        beats_next    = beats_reg;
        bpb_next      = bpb_reg;
        note_next     = note_reg;
        gdiv_next     = gdiv_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LOOP_LEN:    loop_len_next = cfg_data[LEN_W-1:0];
                REG_TOTAL_BEATS: beats_next    = cfg_data[BEATS_W-1:0];
                REG_BEATS_BAR:   bpb_next      = cfg_data[BYTE_W-1:0];
                REG_NOTE_VALUE:  note_next     = cfg_data[BYTE_W-1:0];
                REG_GRID_DIV:    gdiv_next     = cfg_data[GDIV_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        num_next = '0;
        den_next = DEN_W'(1);
        if (beats_next != '0 && bpb_next != '0 && note_next != '0)
        begin
            unique case (gdiv_next)
                GDIV_BAR:
                begin
                    num_next = NUM_W'(beats_next);
                    den_next = bpb_next;
                end
                GDIV_HALF:
                begin
                    num_next = NUM_W'({beats_next, 1'b0});
                    den_next = note_next;
                end
                GDIV_QUARTER:
                begin
                    num_next = NUM_W'({beats_next, 2'b0});
                    den_next = note_next;
                end
                GDIV_EIGHTH:
                begin
                    num_next = NUM_W'({beats_next, 3'b0});
                    den_next = note_next;
                end
                GDIV_SIXTEENTH:
                begin
                    num_next = NUM_W'({beats_next, 4'b0});
                    den_next = note_next;
                end
                default: ;
            endcase
        end
        span_next = SPAN_W'(loop_len_next) * SPAN_W'(den_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_len_reg <= '0;
            beats_reg    <= '0;
            bpb_reg      <= BYTE_W'(4);
            note_reg     <= BYTE_W'(4);
            gdiv_reg     <= GDIV_OFF;
            num_reg      <= '0;
            den_reg      <= DEN_W'(1);
            span_reg     <= '0;
        end
        else
        begin
            loop_len_reg <= loop_len_next;
            beats_reg    <= beats_next;
            bpb_reg      <= bpb_next;
            note_reg     <= note_next;
            gdiv_reg     <= gdiv_next;
            num_reg      <= num_next;
            den_reg      <= den_next;
            span_reg     <= span_next;
        end
    end

    assign cfg.loop_len   = loop_len_reg;
    assign cfg.ratio_num  = num_reg;
    assign cfg.ratio_den  = den_reg;
    assign cfg.span       = span_reg;
    assign cfg.grid_valid = (num_reg != '0) && (den_reg != '0);

endmodule
`default_nettype wire

FILE: sv/llsg_divpipe.sv
`default_nettype none
module llsg_divpipe #(
    parameter int DVD_W  = 51,
    parameter int DIV_W  = 39,
    parameter int Q_W    = 20,
    parameter int SIDE_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [DVD_W-1:0]  dividend,
    input  wire logic [DIV_W-1:0]  divisor,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [Q_W-1:0]         quotient,
    output logic [SIDE_W-1:0]      out_side
);
    import llsg_pkg::*;

    logic [DIV_W-1:0]  rem_reg  [Q_W];
    logic [Q_W-1:0]    low_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];
    logic [Q_W-1:0]    valid_reg;

    logic [DIV_W-1:0]  rem_in   [Q_W];
    logic [Q_W-1:0]    low_in   [Q_W];
    logic [SIDE_W-1:0] side_in  [Q_W];
    logic [Q_W-1:0]    valid_in;

    assign rem_in[0]   = DIV_W'(dividend[DVD_W-1:Q_W]);
    assign low_in[0]   = dividend[Q_W-1:0];
    assign side_in[0]  = in_side;
    assign valid_in[0] = in_valid;

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        logic [DIV_W:0] trial;
        logic [DIV_W:0] diff;
        logic           fits;

        if (k > 0)
        begin : g_link
            assign rem_in[k]   = rem_reg[k-1];
            assign low_in[k]   = low_reg[k-1];
            assign side_in[k]  = side_reg[k-1];
            assign valid_in[k] = valid_reg[k-1];
        end

        assign trial = {rem_in[k], low_in[k][Q_W-1]};
        assign fits  = trial >= {1'b0, divisor};
        assign diff  = trial - {1'b0, divisor};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_in[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                low_reg[k]  <= {low_in[k][Q_W-2:0], fits};
                side_reg[k] <= side_in[k];
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign quotient  = low_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule
`default_nettype wire

FILE: sv/loop_locked_subdivision_grid_unit.sv
// Loop-locked subdivision grid.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// index 0 loop length, 1 total beats, 2 beats per bar, 3 beat note value,
// 4 grid division. cfg_ready is always high; write only while no request
// is in flight.
// Slave channel: s_tdata carries one signed frame position per request.
// Master channel: m_tdata carries next boundary and subdivision index,
// m_tuser the grid valid flag.
// The pipeline is one entry stage with the index multiply, 20 steps of
// the index divider, one stage for the boundary multiply, 40 steps of
// the boundary divider and the output register. Throughput is one
// request per cycle unless the master side stalls; every stage advances
// together. When the master side stalls with a result held, the whole
// pipeline holds and s_tready drops; nothing is lost or repeated.
// Reset clears all valid bits and returns the registers to loop length 0,
// total beats 0, signature 4/4 and division off.
`default_nettype none
module loop_locked_subdivision_grid_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [llsg_pkg::CIDX_W-1:0]  cfg_index,
    input  wire logic [llsg_pkg::CDATA_W-1:0] cfg_data,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [llsg_pkg::POS_W-1:0]   s_tdata,   // [31:0] position
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [llsg_pkg::OUT_W-1:0]        m_tdata,   // [31:0] next_boundary, [51:32] subdiv_index
    output logic                              m_tuser    // [0] grid_valid
);
    import llsg_pkg::*;

    localparam int PROD1_W = LEN_W + NUM_W;
    localparam int PROD2_W = IDX_W + 1 + SPAN_W;
    localparam int Q2_W    = SPAN_W + 1;
    localparam int SIDE1_W = 2 + LEN_W;
    localparam int SIDE2_W = 2 + IDX_W + LEN_W;

    cfg_t cfg;
    logic en;

    llsg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign cfg_ready = 1'b1;

    logic               out_valid_reg;
    logic [POS_W-1:0]   bound_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               gv_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    logic               s1_valid_reg;
    logic [PROD1_W-1:0] s1_prod_reg;
    logic [SIDE1_W-1:0] s1_side_reg;
    logic               in_bad;

    assign in_bad = !cfg.grid_valid || (cfg.loop_len == '0) || s_tdata[POS_W-1]
                    || (s_tdata[LEN_W-1:0] >= cfg.loop_len);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_prod_reg <= PROD1_W'(s_tdata[LEN_W-1:0]) * PROD1_W'(cfg.ratio_num);
            s1_side_reg <= {in_bad, cfg.grid_valid, s_tdata[LEN_W-1:0]};
        end
    end

    logic               d1_valid;
    logic [IDX_W-1:0]   d1_q;
    logic [SIDE1_W-1:0] d1_side;

    llsg_divpipe #(
        .DVD_W  (PROD1_W),
        .DIV_W  (SPAN_W),
        .Q_W    (IDX_W),
        .SIDE_W (SIDE1_W)
    ) u_div_idx (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .dividend  (s1_prod_reg),
        .divisor   (cfg.span),
        .in_side   (s1_side_reg),
        .out_valid (d1_valid),
        .quotient  (d1_q),
        .out_side  (d1_side)
    );

    logic               s2_valid_reg;
    logic [PROD2_W-1:0] s2_prod_reg;
    logic [SIDE2_W-1:0] s2_side_reg;
    logic [IDX_W:0]     idx_inc;
    logic [PROD2_W-1:0] span_mul;

    assign idx_inc  = {1'b0, d1_q} + (IDX_W+1)'(1);
    assign span_mul = PROD2_W'(idx_inc) * PROD2_W'(cfg.span);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= d1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_prod_reg <= span_mul + PROD2_W'(cfg.ratio_num) - PROD2_W'(1);
            s2_side_reg <= {d1_side[SIDE1_W-1:SIDE1_W-2], d1_q, d1_side[LEN_W-1:0]};
        end
    end

    logic               d2_valid;
    logic [Q2_W-1:0]    d2_q;
    logic [SIDE2_W-1:0] d2_side;

    llsg_divpipe #(
        .DVD_W  (PROD2_W),
        .DIV_W  (NUM_W),
        .Q_W    (Q2_W),
        .SIDE_W (SIDE2_W)
    ) u_div_bound (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .dividend  (s2_prod_reg),
        .divisor   (cfg.ratio_num),
        .in_side   (s2_side_reg),
        .out_valid (d2_valid),
        .quotient  (d2_q),
        .out_side  (d2_side)
    );

    logic             fin_bad;
    logic             fin_gv;
    logic [IDX_W-1:0] fin_idx;
    logic [LEN_W-1:0] fin_pos;
    logic [LEN_W-1:0] clamped;
    logic [LEN_W-1:0] bound;

    assign fin_bad = d2_side[SIDE2_W-1];
    assign fin_gv  = d2_side[SIDE2_W-2];
    assign fin_idx = d2_side[LEN_W +: IDX_W];
    assign fin_pos = d2_side[LEN_W-1:0];

    always_comb
    begin
        clamped = (d2_q > Q2_W'(cfg.loop_len)) ? cfg.loop_len : d2_q[LEN_W-1:0];
        bound   = (clamped <= fin_pos) ? cfg.loop_len : clamped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= d2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bound_reg <= fin_bad ? '1 : {1'b0, bound};
            idx_reg   <= fin_bad ? '0 : fin_idx;
            gv_reg    <= fin_gv;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_W-POS_W-IDX_W)'(0), idx_reg, bound_reg};
    assign m_tuser  = gv_reg;

    a_invalid_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bound_reg[POS_W-1]) |-> (idx_reg == '0))
        else $error("invalid result with nonzero index");

    a_bound_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !bound_reg[POS_W-1])
            |-> (bound_reg[LEN_W-1:0] <= cfg.loop_len))
        else $error("boundary beyond loop length");

    a_no_grid_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !gv_reg) |-> (bound_reg == '1))
        else $error("result marked usable without a grid");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(bound_reg)))
        else $error("held result changed under stall");

endmodule
`default_nettype wire
